// ----- design/qti_pkg.sv -----
package qti_pkg;

    localparam int CW       = 112;
    localparam int TAU_BITS = 32;
    localparam int RW       = 65;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;

    typedef logic signed [CW-1:0] coef_t;

    typedef struct packed {
        logic signed [31:0] start_pos;
        logic signed [31:0] start_vel;
        logic signed [31:0] start_acc;
        logic signed [31:0] end_pos;
        logic signed [31:0] end_vel;
        logic signed [31:0] end_acc;
        logic [31:0]        sample_time;
        logic [31:0]        duration;
    } qti_in_t;

    typedef struct packed {
        qti_in_t             item;
        logic [TAU_BITS-1:0] tau;
        logic                one;
    } qti_tau_t;

    typedef struct packed {
        coef_t [5:0]         a;
        logic [TAU_BITS-1:0] tau;
        logic                one;
        logic [31:0]         dur;
        logic [63:0]         dur2;
        logic                zero;
    } qti_coef_t;

    typedef struct packed {
        coef_t       hp;
        coef_t       hv;
        coef_t       ha;
        logic [31:0] dur;
        logic [63:0] dur2;
        logic        zero;
    } qti_poly_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic               saturated;
        logic               zero_duration;
    } qti_res_t;

endpackage

// ----- design/qti_tau_div.sv -----
module qti_tau_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qti_pkg::qti_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qti_pkg::qti_tau_t  out_data
);

    localparam int N = qti_pkg::TAU_BITS;

    typedef struct packed {
        qti_pkg::qti_in_t item;
        logic [31:0]      rem;
        logic [N-1:0]     q;
    } div_t;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_in;
    logic [N-1:0] en;
    div_t         stg_reg  [N];
    div_t         stg_next [N];
    div_t         init;

    function automatic div_t div_step(div_t s);
        logic [32:0] r2;
        logic        ge;
        div_t        r;
        r  = s;
        r2 = {s.rem, 1'b0};
        ge = r2 >= {1'b0, s.item.duration};
        r.rem = ge ? 32'(r2 - {1'b0, s.item.duration}) : r2[31:0];
        r.q   = {s.q[N-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        logic go;
        go = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || go;
            go    = en[i];
        end
    end

    assign in_ready = en[0];
    assign valid_in = {valid_reg[N-2:0], in_valid};

    always_comb
    begin
        init.item = in_data;
        init.rem  = in_data.sample_time;
        init.q    = '0;
        stg_next[0] = div_step(init);
        for (int i = 1; i < N; i++)
        begin
            stg_next[i] = div_step(stg_reg[i-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (en[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign out_valid     = valid_reg[N-1];
    assign out_data.item = stg_reg[N-1].item;
    assign out_data.tau  = stg_reg[N-1].q;
    assign out_data.one  = stg_reg[N-1].item.sample_time >= stg_reg[N-1].item.duration;

endmodule

// ----- design/qti_coef.sv -----
module qti_coef (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qti_pkg::qti_tau_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qti_pkg::qti_coef_t  out_data
);

    localparam int CW = qti_pkg::CW;

    typedef struct packed {
        logic signed [63:0] mv0;
        logic signed [63:0] mvf;
        logic signed [63:0] ma0;
        logic signed [63:0] maf;
        logic signed [32:0] h;
        logic signed [31:0] p0;
        logic [31:0]        tau;
        logic               one;
        logic [31:0]        dur;
        logic [63:0]        dur2;
    } c1_t;

    typedef struct packed {
        logic signed [63:0] mv0;
        logic signed [63:0] mvf;
        logic [63:0]        a0lo;
        logic [63:0]        aflo;
        logic signed [64:0] a0hi;
        logic signed [64:0] afhi;
        logic signed [32:0] h;
        logic signed [31:0] p0;
        logic [31:0]        tau;
        logic               one;
        logic [31:0]        dur;
        logic [63:0]        dur2;
    } c2_t;

    typedef struct packed {
        qti_pkg::coef_t ch;
        qti_pkg::coef_t cv0;
        qti_pkg::coef_t cvf;
        qti_pkg::coef_t ca0;
        qti_pkg::coef_t caf;
        qti_pkg::coef_t cp0;
        logic [31:0]    tau;
        logic           one;
        logic [31:0]    dur;
        logic [63:0]    dur2;
    } c3_t;

    logic [3:0]         valid_reg;
    logic [3:0]         valid_in;
    logic [3:0]         en;
    c1_t                c1_reg, c1_next;
    c2_t                c2_reg, c2_next;
    c3_t                c3_reg, c3_next;
    qti_pkg::qti_coef_t c4_reg, c4_next;

    always_comb
    begin
        logic go;
        go = out_ready;
        for (int i = 3; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || go;
            go    = en[i];
        end
    end

    assign in_ready = en[0];
    assign valid_in = {valid_reg[2:0], in_valid};

    always_comb
    begin
        logic signed [32:0] dur_s;
        dur_s = $signed({1'b0, in_data.item.duration});
        c1_next.mv0  = 64'($signed(in_data.item.start_vel) * dur_s);
        c1_next.mvf  = 64'($signed(in_data.item.end_vel) * dur_s);
        c1_next.ma0  = 64'($signed(in_data.item.start_acc) * dur_s);
        c1_next.maf  = 64'($signed(in_data.item.end_acc) * dur_s);
        c1_next.h    = 33'($signed(in_data.item.end_pos)) - 33'($signed(in_data.item.start_pos));
        c1_next.p0   = in_data.item.start_pos;
        c1_next.tau  = in_data.tau;
        c1_next.one  = in_data.one;
        c1_next.dur  = in_data.item.duration;
        c1_next.dur2 = 64'(in_data.item.duration) * 64'(in_data.item.duration);
    end

    always_comb
    begin
        logic signed [32:0] dur_s;
        dur_s = $signed({1'b0, c1_reg.dur});
        c2_next.mv0  = c1_reg.mv0;
        c2_next.mvf  = c1_reg.mvf;
        c2_next.a0lo = 64'(c1_reg.ma0[31:0]) * 64'(c1_reg.dur);
        c2_next.aflo = 64'(c1_reg.maf[31:0]) * 64'(c1_reg.dur);
        c2_next.a0hi = 65'($signed(c1_reg.ma0[63:32]) * dur_s);
        c2_next.afhi = 65'($signed(c1_reg.maf[63:32]) * dur_s);
        c2_next.h    = c1_reg.h;
        c2_next.p0   = c1_reg.p0;
        c2_next.tau  = c1_reg.tau;
        c2_next.one  = c1_reg.one;
        c2_next.dur  = c1_reg.dur;
        c2_next.dur2 = c1_reg.dur2;
    end

    always_comb
    begin
        c3_next.ch   = qti_pkg::coef_t'(c2_reg.h) <<< 33;
        c3_next.cv0  = qti_pkg::coef_t'(c2_reg.mv0) <<< 17;
        c3_next.cvf  = qti_pkg::coef_t'(c2_reg.mvf) <<< 17;
        c3_next.ca0  = (qti_pkg::coef_t'(c2_reg.a0hi) <<< 32) + CW'(c2_reg.a0lo);
        c3_next.caf  = (qti_pkg::coef_t'(c2_reg.afhi) <<< 32) + CW'(c2_reg.aflo);
        c3_next.cp0  = qti_pkg::coef_t'(c2_reg.p0) <<< 33;
        c3_next.tau  = c2_reg.tau;
        c3_next.one  = c2_reg.one;
        c3_next.dur  = c2_reg.dur;
        c3_next.dur2 = c2_reg.dur2;
    end

    always_comb
    begin
        c4_next.a[0] = c3_reg.cp0;
        c4_next.a[1] = c3_reg.cv0;
        c4_next.a[2] = c3_reg.ca0;
        c4_next.a[3] = c3_reg.ch * 10 - c3_reg.cv0 * 6 - c3_reg.cvf * 4
                     - c3_reg.ca0 * 3 + c3_reg.caf;
        c4_next.a[4] = c3_reg.cv0 * 8 + c3_reg.cvf * 7 + c3_reg.ca0 * 3
                     - c3_reg.ch * 15 - c3_reg.caf * 2;
        c4_next.a[5] = c3_reg.ch * 6 - c3_reg.cv0 * 3 - c3_reg.cvf * 3
                     - c3_reg.ca0 + c3_reg.caf;
        c4_next.tau  = c3_reg.tau;
        c4_next.one  = c3_reg.one;
        c4_next.dur  = c3_reg.dur;
        c4_next.dur2 = c3_reg.dur2;
        c4_next.zero = c3_reg.dur == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg <= c1_next;
        end
        if (en[1])
        begin
            c2_reg <= c2_next;
        end
        if (en[2])
        begin
            c3_reg <= c3_next;
        end
        if (en[3])
        begin
            c4_reg <= c4_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = c4_reg;

endmodule

// ----- design/qti_horner.sv -----
module qti_horner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qti_pkg::qti_coef_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qti_pkg::qti_poly_t  out_data
);

    localparam int CW    = qti_pkg::CW;
    localparam int STEPS = 5;
    localparam int N     = 2 * STEPS;

    typedef struct packed {
        logic [63:0]        p0;
        logic [63:0]        p1;
        logic [63:0]        p2;
        logic signed [48:0] p3;
    } pp_t;

    typedef struct packed {
        qti_pkg::coef_t [5:0] a;
        qti_pkg::coef_t       xp;
        qti_pkg::coef_t       xv;
        qti_pkg::coef_t       xa;
        pp_t                  ppp;
        pp_t                  ppv;
        pp_t                  ppa;
        logic [31:0]          tau;
        logic                 one;
        logic [31:0]          dur;
        logic [63:0]          dur2;
        logic                 zero;
    } hs_t;

    function automatic pp_t pp_calc(qti_pkg::coef_t x, logic [31:0] tau);
        pp_t r;
        r.p0 = 64'(x[31:0]) * 64'(tau);
        r.p1 = 64'(x[63:32]) * 64'(tau);
        r.p2 = 64'(x[95:64]) * 64'(tau);
        r.p3 = 49'($signed(x[CW-1:96]) * $signed({1'b0, tau}));
        return r;
    endfunction

    function automatic qti_pkg::coef_t pp_sum(pp_t p);
        return (qti_pkg::coef_t'(p.p3) <<< 64) + (CW'(p.p2) << 32) + CW'(p.p1)
             + CW'(p.p0[63:32]);
    endfunction

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_in;
    logic [N-1:0] en;
    hs_t          stg_reg  [N];
    hs_t          stg_next [N];
    hs_t          init;

    always_comb
    begin
        logic go;
        go = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || go;
            go    = en[i];
        end
    end

    assign in_ready = en[0];
    assign valid_in = {valid_reg[N-2:0], in_valid};

    always_comb
    begin
        init      = '0;
        init.a    = in_data.a;
        init.xp   = in_data.a[5];
        init.xv   = qti_pkg::coef_t'($signed(in_data.a[5]) * 5);
        init.xa   = qti_pkg::coef_t'($signed(in_data.a[5]) * 20);
        init.tau  = in_data.tau;
        init.one  = in_data.one;
        init.dur  = in_data.dur;
        init.dur2 = in_data.dur2;
        init.zero = in_data.zero;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam int K  = s / 2;
        localparam int IV = (K >= 1) ? 5 - K : 0;
        localparam int IA = (K >= 2) ? 6 - K : 0;
        hs_t src;
        if (s == 0)
        begin : g_first
            assign src = init;
        end
        else
        begin : g_rest
            assign src = stg_reg[s-1];
        end
        if (s % 2 == 0)
        begin : g_prod
            always_comb
            begin
                stg_next[s]     = src;
                stg_next[s].ppp = pp_calc(src.xp, src.tau);
                stg_next[s].ppv = pp_calc(src.xv, src.tau);
                stg_next[s].ppa = pp_calc(src.xa, src.tau);
            end
        end
        else
        begin : g_sum
            always_comb
            begin
                qti_pkg::coef_t tp;
                qti_pkg::coef_t tv;
                qti_pkg::coef_t ta;
                tp = src.one ? src.xp : pp_sum(src.ppp);
                tv = src.one ? src.xv : pp_sum(src.ppv);
                ta = src.one ? src.xa : pp_sum(src.ppa);
                stg_next[s]    = src;
                stg_next[s].xp = $signed(src.a[4-K]) + tp;
                if (K >= 1)
                begin
                    stg_next[s].xv = qti_pkg::coef_t'($signed(src.a[IV]) * (5 - K)) + tv;
                end
                if (K >= 2)
                begin
                    stg_next[s].xa = qti_pkg::coef_t'($signed(src.a[IA]) * ((6 - K) * (5 - K)))
                                   + ta;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (en[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign out_valid     = valid_reg[N-1];
    assign out_data.hp   = stg_reg[N-1].xp;
    assign out_data.hv   = stg_reg[N-1].xv;
    assign out_data.ha   = stg_reg[N-1].xa;
    assign out_data.dur  = stg_reg[N-1].dur;
    assign out_data.dur2 = stg_reg[N-1].dur2;
    assign out_data.zero = stg_reg[N-1].zero;

endmodule

// ----- design/qti_norm.sv -----
module qti_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qti_pkg::qti_poly_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qti_pkg::qti_res_t   out_data
);

    localparam int CW    = qti_pkg::CW;
    localparam int RW    = qti_pkg::RW;
    localparam int QB    = 32;
    localparam int NDIV  = 2 + QB;
    localparam int N     = NDIV + 1;

    typedef struct packed {
        logic          neg_v;
        logic          neg_a;
        logic          ovf_v;
        logic          ovf_a;
        logic [CW-1:0] mag_v;
        logic [CW-1:0] mag_a;
        logic [RW-1:0] d_v;
        logic [RW-1:0] d_a;
        logic [RW-1:0] rem_v;
        logic [RW-1:0] rem_a;
        logic [QB-1:0] lo_v;
        logic [QB-1:0] lo_a;
        logic [QB-1:0] q_v;
        logic [QB-1:0] q_a;
        logic [31:0]   pos_val;
        logic          pos_sat;
        logic          zero;
    } nrm_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] lo;
        logic [QB-1:0] q;
    } dstep_t;

    function automatic dstep_t div_step(dstep_t s, logic [RW-1:0] d);
        logic [RW:0] r2;
        logic        ge;
        dstep_t      r;
        r2    = {s.rem, s.lo[QB-1]};
        ge    = r2 >= {1'b0, d};
        r.rem = ge ? RW'(r2 - {1'b0, d}) : r2[RW-1:0];
        r.lo  = {s.lo[QB-2:0], 1'b0};
        r.q   = {s.q[QB-2:0], ge};
        return r;
    endfunction

    function automatic logic [32:0] sat_fix(logic neg, logic ovf, logic [QB-1:0] q);
        logic        sat;
        logic [31:0] val;
        sat = 1'b0;
        val = q;
        if (ovf)
        begin
            sat = 1'b1;
            val = neg ? qti_pkg::NEG_MIN : qti_pkg::POS_MAX;
        end
        else if (neg)
        begin
            if (q > 32'h8000_0000)
            begin
                sat = 1'b1;
                val = qti_pkg::NEG_MIN;
            end
            else
            begin
                val = 32'(-q);
            end
        end
        else if (q[QB-1])
        begin
            sat = 1'b1;
            val = qti_pkg::POS_MAX;
        end
        return {sat, val};
    endfunction

    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_in;
    logic [N-1:0]      en;
    nrm_t              stg_reg  [NDIV];
    nrm_t              stg_next [NDIV];
    qti_pkg::qti_res_t res_reg;
    qti_pkg::qti_res_t res_next;

    always_comb
    begin
        logic go;
        go = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || go;
            go    = en[i];
        end
    end

    assign in_ready = en[0];
    assign valid_in = {valid_reg[N-2:0], in_valid};

    always_comb
    begin
        logic [CW-1:0] mag_p;
        logic [32:0]   pf;
        mag_p = (in_data.hp[CW-1] ? CW'(-in_data.hp) : CW'(in_data.hp)) + (CW'(1) << 32);
        pf    = sat_fix(in_data.hp[CW-1], |mag_p[CW-1:65], mag_p[64:33]);
        stg_next[0]         = '0;
        stg_next[0].neg_v   = in_data.hv[CW-1];
        stg_next[0].neg_a   = in_data.ha[CW-1];
        stg_next[0].mag_v   = (in_data.hv[CW-1] ? CW'(-in_data.hv) : CW'(in_data.hv))
                            + (CW'(in_data.dur) << 16);
        stg_next[0].mag_a   = (in_data.ha[CW-1] ? CW'(-in_data.ha) : CW'(in_data.ha))
                            + CW'(in_data.dur2);
        stg_next[0].d_v     = RW'(in_data.dur) << 17;
        stg_next[0].d_a     = RW'(in_data.dur2) << 1;
        stg_next[0].pos_val = pf[31:0];
        stg_next[0].pos_sat = pf[32];
        stg_next[0].zero    = in_data.zero;
    end

    always_comb
    begin
        stg_next[1]       = stg_reg[0];
        stg_next[1].ovf_v = stg_reg[0].mag_v[CW-1:QB] >= (CW-QB)'(stg_reg[0].d_v);
        stg_next[1].ovf_a = stg_reg[0].mag_a[CW-1:QB] >= (CW-QB)'(stg_reg[0].d_a);
        stg_next[1].rem_v = stg_reg[0].mag_v[QB+RW-1:QB];
        stg_next[1].rem_a = stg_reg[0].mag_a[QB+RW-1:QB];
        stg_next[1].lo_v  = stg_reg[0].mag_v[QB-1:0];
        stg_next[1].lo_a  = stg_reg[0].mag_a[QB-1:0];
        stg_next[1].q_v   = '0;
        stg_next[1].q_a   = '0;
    end

    for (genvar i = 2; i < NDIV; i++)
    begin : g_div
        always_comb
        begin
            dstep_t sv;
            dstep_t sa;
            sv = div_step({stg_reg[i-1].rem_v, stg_reg[i-1].lo_v, stg_reg[i-1].q_v},
                          stg_reg[i-1].d_v);
            sa = div_step({stg_reg[i-1].rem_a, stg_reg[i-1].lo_a, stg_reg[i-1].q_a},
                          stg_reg[i-1].d_a);
            stg_next[i]       = stg_reg[i-1];
            stg_next[i].rem_v = sv.rem;
            stg_next[i].lo_v  = sv.lo;
            stg_next[i].q_v   = sv.q;
            stg_next[i].rem_a = sa.rem;
            stg_next[i].lo_a  = sa.lo;
            stg_next[i].q_a   = sa.q;
        end
    end

    always_comb
    begin
        logic [32:0] vf;
        logic [32:0] af;
        vf = sat_fix(stg_reg[NDIV-1].neg_v, stg_reg[NDIV-1].ovf_v, stg_reg[NDIV-1].q_v);
        af = sat_fix(stg_reg[NDIV-1].neg_a, stg_reg[NDIV-1].ovf_a, stg_reg[NDIV-1].q_a);
        if (stg_reg[NDIV-1].zero)
        begin
            res_next = '0;
            res_next.zero_duration = 1'b1;
        end
        else
        begin
            res_next.position      = stg_reg[NDIV-1].pos_val;
            res_next.velocity      = vf[31:0];
            res_next.acceleration  = af[31:0];
            res_next.saturated     = stg_reg[NDIV-1].pos_sat | vf[32] | af[32];
            res_next.zero_duration = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NDIV; i++)
        begin
            if (en[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (en[N-1])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_data  = res_reg;

    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_reg.zero_duration |->
            res_reg.position == '0 && res_reg.velocity == '0 &&
            res_reg.acceleration == '0 && !res_reg.saturated)
        else $error("zero duration item with nonzero result");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_reg.saturated |->
            res_reg.position == qti_pkg::POS_MAX || res_reg.position == qti_pkg::NEG_MIN ||
            res_reg.velocity == qti_pkg::POS_MAX || res_reg.velocity == qti_pkg::NEG_MIN ||
            res_reg.acceleration == qti_pkg::POS_MAX ||
            res_reg.acceleration == qti_pkg::NEG_MIN)
        else $error("saturated flag without a clipped value");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output side is free");

endmodule

// ----- design/quintic_trajectory_interpolator_core.sv -----
// Quintic trajectory interpolator: each item carries one joint's start and end
// position, velocity and acceleration (signed Q16.16), a sample time and a move
// duration (unsigned Q16.16 s), and yields position, velocity and acceleration at
// that sample, each saturated to Q16.16. The block takes one item per clock
// while m_tready does not stall it, and returns results in order through the
// bit-per-stage tau = t/T divider, the coefficient multipliers, the three Horner
// chains (one partial-product stage and one sum stage per tau step) and the
// rounding and the two bit-per-stage divisions by T and 2*T^2.
// Samples at or past the duration return the end conditions; a zero duration
// returns zeros with zero_duration set; any clipped output sets saturated.
module quintic_trajectory_interpolator_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, sample_time, duration
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // position, velocity, acceleration
    output logic [95:0]  m_tdata,
    // saturated, zero_duration
    output logic [1:0]   m_tuser
);

    qti_pkg::qti_in_t   in_item;
    qti_pkg::qti_tau_t  tau_data;
    qti_pkg::qti_coef_t coef_data;
    qti_pkg::qti_poly_t poly_data;
    qti_pkg::qti_res_t  res_data;
    logic               tau_valid;
    logic               tau_ready;
    logic               coef_valid;
    logic               coef_ready;
    logic               poly_valid;
    logic               poly_ready;

    assign in_item.start_pos   = s_tdata[31:0];
    assign in_item.start_vel   = s_tdata[63:32];
    assign in_item.start_acc   = s_tdata[95:64];
    assign in_item.end_pos     = s_tdata[127:96];
    assign in_item.end_vel     = s_tdata[159:128];
    assign in_item.end_acc     = s_tdata[191:160];
    assign in_item.sample_time = s_tdata[223:192];
    assign in_item.duration    = s_tdata[255:224];

    qti_tau_div u_tau_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (tau_valid),
        .out_ready (tau_ready),
        .out_data  (tau_data)
    );

    qti_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tau_valid),
        .in_ready  (tau_ready),
        .in_data   (tau_data),
        .out_valid (coef_valid),
        .out_ready (coef_ready),
        .out_data  (coef_data)
    );

    qti_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_ready  (coef_ready),
        .in_data   (coef_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    qti_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_data   (poly_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {res_data.acceleration, res_data.velocity, res_data.position};
    assign m_tuser = {res_data.zero_duration, res_data.saturated};

endmodule
